// File: src/stt_pkg.sv
package stt_pkg;

   localparam int NUM_SLOTS_DEF = 8;

   localparam int OPCODE_W = 3;
   localparam int HANDLE_W = 4;
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 3;

   localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SETPER = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_RELOAD = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd4;

   localparam logic [KIND_W-1:0] K_CREATED = 3'd0;
   localparam logic [KIND_W-1:0] K_NOFREE  = 3'd1;
   localparam logic [KIND_W-1:0] K_DONE    = 3'd2;
   localparam logic [KIND_W-1:0] K_EXPIRED = 3'd3;
   localparam logic [KIND_W-1:0] K_IGNORED = 3'd4;

   // update request for the per-slot flag table
   typedef struct packed {
      logic create;
      logic remove;
      logic activate;
      logic deactivate;
      logic auto_reload;
      logic start_active;
   } flag_cmd_type;

endpackage

// File: src/stt_ram.sv
module stt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/stt_flags.sv
module stt_flags
   import stt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  flag_cmd_type         cmd,
   input  logic [SLOT_W-1:0]    idx,
   output logic [NUM_SLOTS-1:0] in_use,
   output logic [NUM_SLOTS-1:0] active,
   output logic [NUM_SLOTS-1:0] auto_reload
);

   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] auto_ff, auto_in;

   always_comb begin
      in_use_in = in_use_ff;
      active_in = active_ff;
      auto_in   = auto_ff;
      if (cmd.create) begin
         in_use_in[idx] = 1'b1;
         active_in[idx] = cmd.start_active;
         auto_in[idx]   = cmd.auto_reload;
      end
      if (cmd.remove) begin
         in_use_in[idx] = 1'b0;
         active_in[idx] = 1'b0;
      end
      if (cmd.activate) begin
         active_in[idx] = 1'b1;
      end
      if (cmd.deactivate) begin
         active_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         active_ff <= '0;
         auto_ff   <= '0;
      end else begin
         in_use_ff <= in_use_in;
         active_ff <= active_in;
         auto_ff   <= auto_in;
      end
   end

   assign in_use      = in_use_ff;
   assign active      = active_ff;
   assign auto_reload = auto_ff;

endmodule

// File: src/software_timer_table.sv
// Timer slot table: create, set period, reload, delete and tick on up to NUM_SLOTS slots.
// A single-result operation captures the request and then writes its result to the result
// register; a tick scans one slot per cycle while the result side keeps up, then offers
// its final result. One item is in work at a time, and the result side can stall it;
// req_stall holds until the last result is in the result register.
// Synchronous active-high reset clears slot flags, controller and result register, not memories.
module software_timer_table
   import stt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic [TIME_W-1:0]   req_period,
   input  logic                req_auto_reload,
   input  logic                req_start_active,
   input  logic [TIME_W-1:0]   req_now,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [HANDLE_W-1:0] rsp_result_handle,
   output logic                rsp_last
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   // Controller states: wait for a transfer, run a single-result operation,
   // sweep the slots for a tick, then close the tick with its final result.
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_SCAN  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Captured request (payload, no reset)
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [TIME_W-1:0]   period_ff, period_in;
   logic                ar_ff, ar_in;
   logic                sa_ff, sa_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // Tick sweep: slot whose memory data is on the read ports, and the
   // expired handle held back until we know whether it is the last one.
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [HANDLE_W-1:0] pend_handle_ff, pend_handle_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_last_ff, rsp_last_in;

   // Memory ports
   logic [SLOT_W-1:0] rd_addr;
   logic [TIME_W-1:0] period_rd, expiry_rd;
   logic              per_wr_en, exp_wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [TIME_W-1:0] per_wr_data, exp_wr_data;

   // Flag table
   flag_cmd_type         flag_cmd;
   logic [SLOT_W-1:0]    flag_idx;
   logic [NUM_SLOTS-1:0] in_use, active, auto_reload;

   // Derived
   logic                out_free;
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;
   logic [HANDLE_W-1:0] hslot_m1, req_m1;
   logic [SLOT_W-1:0]   hslot, req_slot;
   logic                handle_bad;
   logic                fire;
   logic [SLOT_W:0]     scan_plus1, free_plus1;

   stt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (wr_addr),
      .wr_data (per_wr_data),
      .rd_addr (rd_addr),
      .rd_data (period_rd)
   );

   stt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_expiry_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (wr_addr),
      .wr_data (exp_wr_data),
      .rd_addr (rd_addr),
      .rd_data (expiry_rd)
   );

   stt_flags #(.NUM_SLOTS(NUM_SLOTS)) u_flags (
      .clock       (clock),
      .reset       (reset),
      .cmd         (flag_cmd),
      .idx         (flag_idx),
      .in_use      (in_use),
      .active      (active),
      .auto_reload (auto_reload)
   );

   // Lowest free slot for create
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign req_m1     = req_handle - 1'b1;
   assign req_slot   = SLOT_W'(req_m1);
   assign hslot_m1   = handle_ff - 1'b1;
   assign hslot      = SLOT_W'(hslot_m1);
   assign handle_bad = (handle_ff == '0) || (32'(handle_ff) > 32'(NUM_SLOTS));
   assign scan_plus1 = (SLOT_W+1)'(scan_idx_ff) + 1'b1;
   assign free_plus1 = (SLOT_W+1)'(free_idx) + 1'b1;

   // A slot fires when it is in use, running and its expiry has been reached
   assign fire = in_use[scan_idx_ff] && active[scan_idx_ff] && (now_ff >= expiry_rd);

   // The result register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      handle_in      = handle_ff;
      period_in      = period_ff;
      ar_in          = ar_ff;
      sa_in          = sa_ff;
      now_in         = now_ff;
      scan_idx_in    = scan_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;

      // hold the result until it is transferred
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;

      rd_addr     = hslot;
      per_wr_en   = 1'b0;
      exp_wr_en   = 1'b0;
      wr_addr     = hslot;
      per_wr_data = period_ff;
      exp_wr_data = now_ff + period_rd;
      flag_cmd    = '0;
      flag_idx    = hslot;

      case (state_ff)
         S_IDLE: begin
            rd_addr = req_slot;
            if (req_valid) begin
               op_in     = req_opcode;
               handle_in = req_handle;
               period_in = req_period;
               ar_in     = req_auto_reload;
               sa_in     = req_start_active;
               now_in    = req_now;
               if (req_opcode == OP_TICK) begin
                  // start the sweep at slot zero
                  rd_addr       = '0;
                  scan_idx_in   = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            // keep the period read for reload valid while stalled
            rd_addr = hslot;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               rsp_kind_in   = K_IGNORED;
               case (op_ff)
                  OP_CREATE: begin
                     if (free_found) begin
                        wr_addr               = free_idx;
                        flag_idx              = free_idx;
                        per_wr_en             = 1'b1;
                        per_wr_data           = period_ff;
                        exp_wr_en             = sa_ff;
                        exp_wr_data           = now_ff + period_ff;
                        flag_cmd.create       = 1'b1;
                        flag_cmd.auto_reload  = ar_ff;
                        flag_cmd.start_active = sa_ff;
                        rsp_kind_in           = K_CREATED;
                        rsp_handle_in         = HANDLE_W'(free_plus1);
                     end else begin
                        rsp_kind_in = K_NOFREE;
                     end
                  end
                  OP_SETPER: begin
                     if (!handle_bad) begin
                        per_wr_en   = 1'b1;
                        rsp_kind_in = K_DONE;
                     end
                  end
                  OP_RELOAD: begin
                     if (!handle_bad) begin
                        exp_wr_en         = 1'b1;
                        exp_wr_data       = now_ff + period_rd;
                        flag_cmd.activate = 1'b1;
                        rsp_kind_in       = K_DONE;
                     end
                  end
                  OP_DELETE: begin
                     if (!handle_bad) begin
                        flag_cmd.remove = 1'b1;
                        rsp_kind_in     = K_DONE;
                     end
                  end
                  default: begin
                     rsp_kind_in = K_IGNORED;
                  end
               endcase
               state_in = S_IDLE;
            end
         end

         S_SCAN: begin
            wr_addr  = scan_idx_ff;
            flag_idx = scan_idx_ff;
            if (fire && pend_valid_ff && !out_free) begin
               // result side is full: re-read this slot and wait
               rd_addr = scan_idx_ff;
            end else begin
               rd_addr = SLOT_W'(scan_plus1);
               if (fire) begin
                  // reload or stop the expired slot
                  exp_wr_en           = auto_reload[scan_idx_ff];
                  exp_wr_data         = now_ff + period_rd;
                  flag_cmd.deactivate = !auto_reload[scan_idx_ff];
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = K_EXPIRED;
                     rsp_handle_in = pend_handle_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_handle_in = HANDLE_W'(scan_plus1);
               end
               if (scan_idx_ff == LAST_SLOT) begin
                  state_in = S_FLUSH;
               end else begin
                  scan_idx_in = SLOT_W'(scan_plus1);
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in   = K_EXPIRED;
                  rsp_handle_in = pend_handle_ff;
               end else begin
                  rsp_kind_in   = K_DONE;
                  rsp_handle_in = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      handle_ff      <= handle_in;
      period_ff      <= period_in;
      ar_ff          <= ar_in;
      sa_ff          <= sa_in;
      now_ff         <= now_in;
      scan_idx_ff    <= scan_idx_in;
      pend_handle_ff <= pend_handle_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// File: src/stt_checker.sv
module stt_checker
   import stt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [HANDLE_W-1:0] rsp_result_handle,
   input logic                rsp_last
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a non-final tick result means the tick is still in work
   a_busy_mid_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request side open during an unfinished tick");

   // only expired results can be non-final
   a_mid_is_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == K_EXPIRED)
      else $error("non-final result is not an expiry");

   // created and expired carry a handle, the others none
   a_handle_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == K_CREATED || rsp_kind == K_EXPIRED)
                     == (rsp_result_handle != '0)))
      else $error("handle does not match result kind");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind software_timer_table stt_checker u_stt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_result_handle (rsp_result_handle),
   .rsp_last          (rsp_last)
);
